// ===== rtl/omec_pkg.sv =====
`timescale 1ns / 1ps

package omec_pkg;

  // Fixed field widths
  localparam int SCR_W     = 14;   // screen size, whole pixels
  localparam int HALF_W    = 20;   // marker half size, fixed point
  localparam int EDGE_W    = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam int REG_IDX_W = 2;

  // Edge codes
  localparam logic [EDGE_W-1:0] EDGE_INSIDE = 3'd0;
  localparam logic [EDGE_W-1:0] EDGE_TOP    = 3'd1;
  localparam logic [EDGE_W-1:0] EDGE_LEFT   = 3'd2;
  localparam logic [EDGE_W-1:0] EDGE_RIGHT  = 3'd3;
  localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_HEIGHT   = 2'd3;

  // Reset values
  localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 14'd1920;
  localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 14'd1080;
  localparam logic [HALF_W-1:0] RST_HALF_WIDTH    = 20'd8192;
  localparam logic [HALF_W-1:0] RST_HALF_HEIGHT   = 20'd8192;

  typedef struct packed {
    logic [SCR_W-1:0]  screen_width;
    logic [SCR_W-1:0]  screen_height;
    logic [HALF_W-1:0] marker_half_width;
    logic [HALF_W-1:0] marker_half_height;
  } omec_cfg_t;

  // Edges are tested top, left, right, bottom
  function automatic logic [EDGE_W-1:0] next_edge(input logic [EDGE_W-1:0] e);
    logic [EDGE_W-1:0] n;
    case (e)
      EDGE_TOP:   n = EDGE_LEFT;
      EDGE_LEFT:  n = EDGE_RIGHT;
      EDGE_RIGHT: n = EDGE_BOTTOM;
      default:    n = EDGE_BOTTOM;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/omec_addsub.sv =====
`timescale 1ns / 1ps

// Shared adder / subtractor. On subtract, carry high means a >= b.
module omec_addsub #(
  parameter int W = 64
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};

endmodule

// ===== rtl/omec_core.sv =====
`timescale 1ns / 1ps

// Edge clamp sequencer: shift-add multiplies, compare and restoring divide,
// all through one shared adder.
module omec_core #(
  parameter int CW = 32,
  parameter int FB = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  omec_pkg::omec_cfg_t          cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [CW-1:0]         in_x,
  input  logic signed [CW-1:0]         in_y,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [CW-1:0]         res_x,
  output logic signed [CW-1:0]         res_y,
  output logic [omec_pkg::EDGE_W-1:0]  res_edge
);

  localparam int SW    = omec_pkg::SCR_W + FB;       // screen size, fixed point
  localparam int MAXCS = (CW > SW) ? CW : SW;
  localparam int DW    = MAXCS + 2;                  // doubled deltas, signed
  localparam int MW    = DW - 1;                     // delta magnitudes
  localparam int PW    = SW + MW + 1;                // products and numerator
  localparam int CNTW  = $clog2(SW);
  localparam int OFFW  = omec_pkg::HALF_W + 1;
  localparam int EW    = ((MAXCS > OFFW) ? MAXCS : OFFW) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SEL, S_MUL_A, S_MUL_B, S_CMP, S_NUM, S_DIV, S_FIN
  } state_t;

  state_t                       state_r, state_nxt;
  logic signed [CW-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic [MW-1:0]                adx_r, adx_nxt, ady_r, ady_nxt;
  logic                         xneg_r, xneg_nxt, xpos_r, xpos_nxt;
  logic                         yneg_r, yneg_nxt, ypos_r, ypos_nxt;
  logic [omec_pkg::EDGE_W-1:0]  edge_r, edge_nxt;
  logic                         hit_r, hit_nxt, tneg_r, tneg_nxt;
  logic [MW-1:0]                tabs_r, tabs_nxt, mcand_r, mcand_nxt;
  logic [SW-1:0]                mplr_r, mplr_nxt, quo_r, quo_nxt;
  logic [CNTW-1:0]              cnt_r, cnt_nxt;
  logic [PW-1:0]                acc_r, acc_nxt, proda_r, proda_nxt, den_r, den_nxt;

  logic [SW-1:0]                wf, hf;
  logic signed [DW-1:0]         px_ext, py_ext, wf_s, hf_s, dx2, dy2, ndx2, ndy2;
  logic                         inside_c;

  logic                         cond_c, tneg_c;
  logic [MW-1:0]                nabs_c, tabs_c;
  logic [SW-1:0]                hn_c, ht_c;
  logic [PW-1:0]                den_init;

  logic [PW-1:0]                alu_a, alu_b, alu_sum;
  logic                         alu_sub, alu_carry;

  logic signed [EW-1:0]         px_e, py_e, wf_e, hf_e, quo_e, mhw_e, mhh_e;
  logic signed [EW-1:0]         xb_e, xo_e, yb_e, yo_e, x_e, y_e;

  // Screen size in fixed point
  assign wf = SW'(cfg.screen_width) << FB;
  assign hf = SW'(cfg.screen_height) << FB;

  // Doubled offsets from the screen center
  assign px_ext = DW'(px_r);
  assign py_ext = DW'(py_r);
  assign wf_s   = $signed(DW'(wf));
  assign hf_s   = $signed(DW'(hf));
  assign dx2    = (px_ext <<< 1) - wf_s;
  assign dy2    = (py_ext <<< 1) - hf_s;
  assign ndx2   = -dx2;
  assign ndy2   = -dy2;
  assign inside_c = !px_r[CW-1] && !py_r[CW-1] && (px_ext <= wf_s) && (py_ext <= hf_s);

  // Operands of the edge under test
  always_comb begin
    case (edge_r)
      omec_pkg::EDGE_TOP: begin
        cond_c = yneg_r; nabs_c = ady_r; tabs_c = adx_r; tneg_c = xneg_r;
        hn_c = hf; ht_c = wf;
      end
      omec_pkg::EDGE_LEFT: begin
        cond_c = xneg_r; nabs_c = adx_r; tabs_c = ady_r; tneg_c = yneg_r;
        hn_c = wf; ht_c = hf;
      end
      omec_pkg::EDGE_RIGHT: begin
        cond_c = xpos_r; nabs_c = adx_r; tabs_c = ady_r; tneg_c = yneg_r;
        hn_c = wf; ht_c = hf;
      end
      default: begin
        cond_c = ypos_r; nabs_c = ady_r; tabs_c = adx_r; tneg_c = xneg_r;
        hn_c = hf; ht_c = wf;
      end
    endcase
  end

  // Divisor 2*nabs, aligned to the top quotient bit
  assign den_init = {1'b0, nabs_c, 1'b0, {(SW-1){1'b0}}};

  // Shared adder operand select
  always_comb begin
    case (state_r)
      S_SEL: begin
        alu_a = PW'(nabs_c); alu_b = PW'(hn_c); alu_sub = 1'b1;
      end
      S_MUL_A, S_MUL_B: begin
        alu_a   = {acc_r[PW-2:0], 1'b0};
        alu_b   = mplr_r[SW-1] ? PW'(mcand_r) : '0;
        alu_sub = 1'b0;
      end
      S_CMP: begin
        alu_a = proda_r; alu_b = acc_r; alu_sub = 1'b1;
      end
      S_NUM: begin
        alu_a = proda_r; alu_b = acc_r; alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_a = acc_r; alu_b = den_r; alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0; alu_b = '0; alu_sub = 1'b0;
      end
    endcase
  end

  omec_addsub #(.W(PW)) u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;    py_nxt    = py_r;
    adx_nxt   = adx_r;   ady_nxt   = ady_r;
    xneg_nxt  = xneg_r;  xpos_nxt  = xpos_r;
    yneg_nxt  = yneg_r;  ypos_nxt  = ypos_r;
    edge_nxt  = edge_r;  hit_nxt   = hit_r;
    tneg_nxt  = tneg_r;  tabs_nxt  = tabs_r;
    mcand_nxt = mcand_r; mplr_nxt  = mplr_r;
    quo_nxt   = quo_r;   cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;   proda_nxt = proda_r;
    den_nxt   = den_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt    = in_x;
          py_nxt    = in_y;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        adx_nxt  = dx2[DW-1] ? ndx2[MW-1:0] : dx2[MW-1:0];
        ady_nxt  = dy2[DW-1] ? ndy2[MW-1:0] : dy2[MW-1:0];
        xneg_nxt = dx2[DW-1];
        xpos_nxt = !dx2[DW-1] && (dx2 != '0);
        yneg_nxt = dy2[DW-1];
        ypos_nxt = !dy2[DW-1] && (dy2 != '0);
        if (inside_c) begin
          edge_nxt  = omec_pkg::EDGE_INSIDE;
          state_nxt = S_FIN;
        end else begin
          edge_nxt  = omec_pkg::EDGE_TOP;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        // point must lie beyond the edge line
        if (cond_c && alu_carry) begin
          mcand_nxt = nabs_c;
          tabs_nxt  = tabs_c;
          tneg_nxt  = tneg_c;
          mplr_nxt  = ht_c;
          acc_nxt   = '0;
          cnt_nxt   = CNTW'(SW - 1);
          state_nxt = S_MUL_A;
        end else if (edge_r == omec_pkg::EDGE_BOTTOM) begin
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          edge_nxt = omec_pkg::next_edge(edge_r);
        end
      end
      S_MUL_A: begin
        // a = edge length * normal distance
        acc_nxt  = alu_sum;
        mplr_nxt = {mplr_r[SW-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          proda_nxt = alu_sum;
          acc_nxt   = '0;
          mcand_nxt = tabs_r;
          mplr_nxt  = hn_c;
          cnt_nxt   = CNTW'(SW - 1);
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        // b = center-to-edge distance * tangential delta
        acc_nxt  = alu_sum;
        mplr_nxt = {mplr_r[SW-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // crossing lies on the edge when b <= a
        if (!alu_carry) begin
          if (edge_r == omec_pkg::EDGE_BOTTOM) begin
            hit_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            edge_nxt  = omec_pkg::next_edge(edge_r);
            state_nxt = S_SEL;
          end
        end else begin
          den_nxt = den_init;
          quo_nxt = '0;
          cnt_nxt = CNTW'(SW - 1);
          if (tneg_r) begin
            acc_nxt   = alu_sum;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_NUM;
          end
        end
      end
      S_NUM: begin
        acc_nxt   = alu_sum;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (alu_carry) begin
          acc_nxt = alu_sum;
        end
        quo_nxt = {quo_r[SW-2:0], alu_carry};
        den_nxt = {1'b0, den_r[PW-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    px_r    <= px_nxt;    py_r    <= py_nxt;
    adx_r   <= adx_nxt;   ady_r   <= ady_nxt;
    xneg_r  <= xneg_nxt;  xpos_r  <= xpos_nxt;
    yneg_r  <= yneg_nxt;  ypos_r  <= ypos_nxt;
    edge_r  <= edge_nxt;  hit_r   <= hit_nxt;
    tneg_r  <= tneg_nxt;  tabs_r  <= tabs_nxt;
    mcand_r <= mcand_nxt; mplr_r  <= mplr_nxt;
    quo_r   <= quo_nxt;   cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;   proda_r <= proda_nxt;
    den_r   <= den_nxt;
  end

  // Result assembly
  assign px_e  = EW'(px_r);
  assign py_e  = EW'(py_r);
  assign wf_e  = $signed(EW'(wf));
  assign hf_e  = $signed(EW'(hf));
  assign quo_e = $signed(EW'(quo_r));
  assign mhw_e = $signed(EW'({cfg.marker_half_width, 1'b0}));
  assign mhh_e = $signed(EW'({cfg.marker_half_height, 1'b0}));

  always_comb begin
    xo_e = '0;
    yo_e = '0;
    case (edge_r)
      omec_pkg::EDGE_INSIDE: begin
        xb_e = px_e; yb_e = py_e;
      end
      omec_pkg::EDGE_TOP: begin
        xb_e = quo_e; yb_e = '0;
      end
      omec_pkg::EDGE_LEFT: begin
        xb_e = '0; yb_e = quo_e;
      end
      omec_pkg::EDGE_RIGHT: begin
        xb_e = wf_e; xo_e = mhw_e; yb_e = quo_e;
      end
      default: begin
        // bottom, or no crossing found: both shift up by the marker height
        xb_e = hit_r ? quo_e : px_e;
        yb_e = hit_r ? hf_e : py_e;
        yo_e = mhh_e;
      end
    endcase
  end

  assign x_e = xb_e - xo_e;
  assign y_e = yb_e - yo_e;

  function automatic logic signed [CW-1:0] sat_fn(input logic signed [EW-1:0] v);
    logic [EW-CW:0] upper;
    logic signed [CW-1:0] r;
    upper = v[EW-1:CW-1];
    if ((&upper) || !(|upper)) begin
      r = v[CW-1:0];
    end else if (v[EW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res_x     = sat_fn(x_e);
  assign res_y     = sat_fn(y_e);
  assign res_edge  = edge_r;

endmodule

// ===== rtl/offscreen_marker_edge_clamp.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// in        in_valid / in_ready           in_target_x, in_target_y
// out       out_valid / out_ready         out_marker_x, out_marker_y, out_edge_hit
// cfg       APB write/read, pready = 1    screen size, marker half size
//
// A point inside the screen goes straight to the result without edge tests. Outside,
// the edges are checked in turn; an edge the point lies beyond takes two
// shift-add products and a compare, and the hit edge adds a restoring divide
// for the crossing coordinate. All these steps share the single adder.
// Reset is synchronous; it restores the register defaults and empties the
// block. A new request is taken while a finished result waits at the output.
module offscreen_marker_edge_clamp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_target_x,
  input  logic signed [COORD_WIDTH-1:0]       in_target_y,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       out_marker_x,
  output logic signed [COORD_WIDTH-1:0]       out_marker_y,
  output logic [omec_pkg::EDGE_W-1:0]         out_edge_hit,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [omec_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [omec_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [omec_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  omec_pkg::omec_cfg_t                  cfg_r, cfg_nxt;
  logic [omec_pkg::REG_IDX_W-1:0]       reg_idx;
  logic                                 cfg_wr;

  logic                                 res_valid, res_ready;
  logic signed [COORD_WIDTH-1:0]        res_x, res_y;
  logic [omec_pkg::EDGE_W-1:0]          res_edge;

  logic                                 out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0]        out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [omec_pkg::EDGE_W-1:0]          out_edge_r, out_edge_nxt;

  // Register file
  assign reg_idx    = cfg_paddr[omec_pkg::APB_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        omec_pkg::REG_SCREEN_WIDTH:
          cfg_nxt.screen_width = cfg_pwdata[omec_pkg::SCR_W-1:0];
        omec_pkg::REG_SCREEN_HEIGHT:
          cfg_nxt.screen_height = cfg_pwdata[omec_pkg::SCR_W-1:0];
        omec_pkg::REG_HALF_WIDTH:
          cfg_nxt.marker_half_width = cfg_pwdata[omec_pkg::HALF_W-1:0];
        omec_pkg::REG_HALF_HEIGHT:
          cfg_nxt.marker_half_height = cfg_pwdata[omec_pkg::HALF_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      omec_pkg::REG_SCREEN_WIDTH:  cfg_prdata = omec_pkg::APB_DW'(cfg_r.screen_width);
      omec_pkg::REG_SCREEN_HEIGHT: cfg_prdata = omec_pkg::APB_DW'(cfg_r.screen_height);
      omec_pkg::REG_HALF_WIDTH:    cfg_prdata = omec_pkg::APB_DW'(cfg_r.marker_half_width);
      omec_pkg::REG_HALF_HEIGHT:   cfg_prdata = omec_pkg::APB_DW'(cfg_r.marker_half_height);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Sequencer and shared datapath
  omec_core #(
    .CW (COORD_WIDTH),
    .FB (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_target_x),
    .in_y      (in_target_y),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_edge  (res_edge)
  );

  // Output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_edge_nxt  = out_edge_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = res_x;
      out_y_nxt     = res_y;
      out_edge_nxt  = res_edge;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cfg_r.screen_width       <= omec_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height      <= omec_pkg::RST_SCREEN_HEIGHT;
      cfg_r.marker_half_width  <= omec_pkg::RST_HALF_WIDTH;
      cfg_r.marker_half_height <= omec_pkg::RST_HALF_HEIGHT;
    end else begin
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_edge_r <= out_edge_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_marker_x = out_x_r;
  assign out_marker_y = out_y_r;
  assign out_edge_hit = out_edge_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core still ready after taking a request");

  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid)
    else $error("finished result not registered at the output");

  a_top_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_hit == omec_pkg::EDGE_TOP) |-> (out_marker_y == '0))
    else $error("top edge hit with nonzero y");

endmodule
